>>> src/dtq_pkg.sv
// Package for the deadline timer queue: sizes, field types and register codes.
// Used by dtq_cell.sv and deadline_timer_queue_core.sv.
package dtq_pkg;
	localparam int Slots = 16;
	localparam int SlotW = $clog2(Slots);
	localparam int MaxResults = 17;
	localparam int ResCntW = $clog2(MaxResults + 1);
	localparam logic [3:0] MarginReset = 4'd2;
	localparam logic [0:0] RegMargin = 1'b0;
	localparam logic ModeStart = 1'b0;
	localparam logic ModeTick = 1'b1;
	localparam logic KindAck = 1'b0;
	localparam logic KindExpire = 1'b1;

	// contents of one timer cell
	typedef struct packed {
		logic        busy;
		logic [63:0] deadline;
		logic [15:0] tag;
		logic [SlotW-1:0] order;
	} cell_t;

	// candidate travelling along the compare chain
	typedef struct packed {
		logic        found;
		logic [63:0] deadline;
		logic [SlotW-1:0] order;
		logic [SlotW-1:0] idx;
	} cand_t;
endpackage

>>> src/deadline_timer_queue_core.sv
// Top level of the deadline timer queue: control, time keeping, cell row, output.
// Depends on dtq_pkg and dtq_cell.
//
// A pool of 16 one-shot timers on a 64-bit microsecond time base. Each request
// (start or tick) is handled one at a time. A start first takes the lowest free
// cell. Every search then sweeps the row of 16 cells through a registered
// compare chain: a scan state lets the chain settle through all cells, then a
// pick state takes the winner. Each timer found starts another search, and each
// result that goes out waits for its handshake. Expiries come out earliest
// deadline first, ties in start order, at most 17 results per request.
module deadline_timer_queue_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // [31:0] duration_us, [47:32] tag
	input  logic        s_axis_tuser,  // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [0] status, [4:1] timer_number, [20:5] expired_tag
	output logic        m_axis_tuser,  // kind
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam logic [2:0] StIdle  = 3'd0;
	localparam logic [2:0] StStart = 3'd1;
	localparam logic [2:0] StScan  = 3'd2;
	localparam logic [2:0] StPick  = 3'd3;
	localparam logic [2:0] StOut   = 3'd4;

	localparam int N = dtq_pkg::Slots;
	localparam int W = dtq_pkg::SlotW;

	logic [2:0]  state_q;
	logic [3:0]  margin_q;
	logic [63:0] now_q;
	logic [63:0] limit_q;
	logic [31:0] dur_q;
	logic [15:0] tag_q;
	logic [W:0]  scan_q;
	logic [dtq_pkg::ResCntW-1:0] res_q;
	logic        pend_q;  // a held result waits for last decision
	logic        out_last_q;

	dtq_pkg::cell_t cells [N];
	dtq_pkg::cand_t chain [N+1];
	logic [N-1:0] busy_vec;
	logic [N-1:0] wr_vec;
	logic [N-1:0] clr_vec;
	logic [W-1:0] free_idx;
	logic         free_found;
	logic [W:0]   busy_cnt;
	dtq_pkg::cell_t new_cell;
	logic [64:0]  lim_sum;
	logic         in_acc, out_acc, cfg_wr;
	dtq_pkg::cand_t best;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign s_axis_tready = (state_q == StIdle);
	assign pready = 1'b1;
	assign prdata = {28'd0, margin_q};
	assign chain[0] = '0;
	assign best = chain[N];

	// free slot search and busy count over the cell row
	always_comb begin
		free_idx = '0;
		free_found = 1'b0;
		busy_cnt = '0;
		for (int i = N - 1; i >= 0; i--) begin
			busy_vec[i] = cells[i].busy;
			if (!cells[i].busy) begin
				free_idx = W'(i);
				free_found = 1'b1;
			end
		end
		for (int i = 0; i < N; i++) begin
			busy_cnt = busy_cnt + (W+1)'(busy_vec[i]);
		end
	end

	assign new_cell = '{busy: 1'b1,
		deadline: now_q + {32'd0, dur_q}, tag: tag_q, order: busy_cnt[W-1:0]};
	assign lim_sum = {1'b0, now_q} + {61'd0, margin_q};

	generate
		for (genvar g = 0; g < N; g++) begin : g_cell
			assign wr_vec[g]  = (state_q == StStart) && free_found && (free_idx == W'(g));
			assign clr_vec[g] = (state_q == StPick) && best.found && (best.idx == W'(g));
			dtq_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.idx        (W'(g)),
				.write_en   (wr_vec[g]),
				.write_data (new_cell),
				.clear_en   (clr_vec[g]),
				.close_en   ((state_q == StPick) && best.found),
				.close_order(best.order),
				.limit      (limit_q),
				.cand_in    (chain[g]),
				.cand_q     (chain[g+1]),
				.cell_q     (cells[g])
			);
		end
	endgenerate

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= dtq_pkg::MarginReset;
		end else if (cfg_wr && paddr == {dtq_pkg::RegMargin, 2'b00}) begin
			margin_q <= pwdata[3:0];
		end
	end

	// request registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			dur_q  <= s_axis_tdata[31:0];
			tag_q  <= s_axis_tdata[47:32];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			now_q <= '0;
			limit_q <= '0;
			scan_q <= '0;
			res_q <= '0;
			pend_q <= 1'b0;
			m_axis_tvalid <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			unique case (state_q)
				StIdle: begin
					if (in_acc) begin
						res_q <= '0;
						if (s_axis_tuser == dtq_pkg::ModeTick) begin
							now_q <= now_q + 64'd1;
							state_q <= StScan;
							scan_q <= '0;
						end else begin
							state_q <= StStart;
						end
					end
				end
				StStart: begin
					pend_q <= 1'b1;
					res_q <= res_q + 1'b1;
					state_q <= StScan;
					scan_q <= '0;
				end
				StScan: begin
					limit_q <= lim_sum[64] ? '1 : lim_sum[63:0];
					if (scan_q == (W+1)'(N + 1)) begin
						state_q <= StPick;
					end
					scan_q <= scan_q + 1'b1;
				end
				StPick: begin
					if (best.found && res_q != dtq_pkg::ResCntW'(dtq_pkg::MaxResults)) begin
						// emit the held result if there is one, hold the new expiry
						if (pend_q) begin
							m_axis_tvalid <= 1'b1;
							out_last_q <= 1'b0;
							state_q <= StOut;
						end else begin
							state_q <= StScan;
							scan_q <= '0;
						end
						pend_q <= 1'b1;
						res_q <= res_q + 1'b1;
					end else if (pend_q) begin
						m_axis_tvalid <= 1'b1;
						out_last_q <= 1'b1;
						pend_q <= 1'b0;
						state_q <= StOut;
					end else begin
						state_q <= StIdle;
					end
				end
				StOut: begin
					if (out_acc) begin
						m_axis_tvalid <= 1'b0;
						if (out_last_q) begin
							state_q <= StIdle;
						end else begin
							state_q <= StScan;
							scan_q <= '0;
						end
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	// next held expiry; loaded in the pick state, valid while an earlier held result waits to go out
	logic        nxt_kind_q;
	logic [3:0]  nxt_num_q;
	logic [15:0] nxt_tag_q;
	logic        nxt_v_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nxt_v_q <= 1'b0;
		end else if (state_q == StPick && best.found && res_q != dtq_pkg::ResCntW'(dtq_pkg::MaxResults)) begin
			nxt_v_q <= pend_q;
		end else if (state_q == StOut && out_acc) begin
			nxt_v_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (state_q == StPick && best.found) begin
			nxt_kind_q <= dtq_pkg::KindExpire;
			nxt_num_q <= 4'(best.idx);
			nxt_tag_q <= cells[best.idx].tag;
		end
	end

	// output view: start acknowledgement, held result, or next one promoted after handshake
	logic [3:0]  shown_num_q;
	logic [15:0] shown_tag_q;
	logic        shown_kind_q, shown_status_q;
	always_ff @(posedge clk) begin
		if (state_q == StPick && best.found && !pend_q) begin
			shown_kind_q <= dtq_pkg::KindExpire;
			shown_status_q <= 1'b0;
			shown_num_q <= 4'(best.idx);
			shown_tag_q <= cells[best.idx].tag;
		end else if (state_q == StStart) begin
			shown_kind_q <= dtq_pkg::KindAck;
			shown_status_q <= !free_found;
			shown_num_q <= free_found ? 4'(free_idx) : 4'd0;
			shown_tag_q <= '0;
		end else if (state_q == StOut && out_acc && nxt_v_q) begin
			shown_kind_q <= nxt_kind_q;
			shown_status_q <= 1'b0;
			shown_num_q <= nxt_num_q;
			shown_tag_q <= nxt_tag_q;
		end
	end

	assign m_axis_tuser = shown_kind_q;
	assign m_axis_tdata = {3'd0, shown_tag_q, shown_num_q, shown_status_q};
	assign m_axis_tlast = out_last_q;

	// ready only when idle, and never while a result is offered
	a_rdy_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid) else $error("ready while output busy");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(wr_vec)) else $error("multiple cells written");
	a_one_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(clr_vec)) else $error("multiple cells cleared");
	a_res_cap: assert property (@(posedge clk) disable iff (!arst_n)
		res_q <= dtq_pkg::ResCntW'(dtq_pkg::MaxResults)) else $error("result count overflow");
endmodule

>>> src/dtq_cell.sv
// One timer cell: holds one timer, joins the registered compare chain.
// Depends on dtq_pkg.
module dtq_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [dtq_pkg::SlotW-1:0] idx,
	input  logic                     write_en,
	input  dtq_pkg::cell_t           write_data,
	input  logic                     clear_en,
	input  logic                     close_en,
	input  logic [dtq_pkg::SlotW-1:0] close_order,
	input  logic [63:0]              limit,
	input  dtq_pkg::cand_t           cand_in,
	output dtq_pkg::cand_t           cand_q,
	output dtq_pkg::cell_t           cell_q
);
	logic due;
	logic better;
	logic                     busy_q;
	logic [63:0]              deadline_q;
	logic [15:0]              tag_q;
	logic [dtq_pkg::SlotW-1:0] order_q;

	// timer storage; busy is control, the rest payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (write_en) begin
			busy_q <= write_data.busy;
		end else if (clear_en) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (write_en) begin
			deadline_q <= write_data.deadline;
			tag_q      <= write_data.tag;
			order_q    <= write_data.order;
		end else if (close_en && busy_q && order_q > close_order) begin
			order_q <= order_q - 1'b1;
		end
	end

	assign cell_q = '{busy: busy_q, deadline: deadline_q, tag: tag_q, order: order_q};

	// compare this cell against the candidate handed in by the neighbor
	assign due = busy_q && (deadline_q <= limit);
	assign better = due && (!cand_in.found || deadline_q < cand_in.deadline ||
		(deadline_q == cand_in.deadline && order_q < cand_in.order));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
		end else if (better) begin
			cand_q <= '{found: 1'b1, deadline: deadline_q, order: order_q, idx: idx};
		end else begin
			cand_q <= cand_in;
		end
	end
endmodule
